@@ rtl/stack_with_undo_stack_unit_defines.svh @@
// Assertion macros used by the checker module.
`ifndef STACK_WITH_UNDO_STACK_UNIT_DEFINES_SVH
`define STACK_WITH_UNDO_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define SWUS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define SWUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/swus_pkg.sv @@
package swus_pkg;

  localparam int DATA_W = 32;
  localparam int DEPTH_FIELD_W = 5;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_MOVE    = 2'd2,
    REQ_RESTORE = 2'd3
  } req_type_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MAIN_EMPTY = 3'd1;
  localparam logic [2:0] ST_UNDO_EMPTY = 3'd2;
  localparam logic [2:0] ST_MAIN_FULL  = 3'd3;
  localparam logic [2:0] ST_UNDO_FULL  = 3'd4;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  out_value;
    logic [2:0]                status;
    logic [DEPTH_FIELD_W-1:0]  main_depth;
    logic [DEPTH_FIELD_W-1:0]  undo_depth;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

@@ rtl/swus_cell.sv @@
module swus_cell (
  input  logic                               clk,
  input  swus_pkg::stk_ctl_t                 ctl,
  input  logic signed [swus_pkg::DATA_W-1:0] above_data,
  input  logic signed [swus_pkg::DATA_W-1:0] below_data,
  output logic signed [swus_pkg::DATA_W-1:0] data_o
);
  import swus_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // A push takes the entry from the cell above, a pop the one from below.
  always_comb begin
    priority if (ctl.push) begin
      data_nxt = above_data;
    end else if (ctl.pop) begin
      data_nxt = below_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

@@ rtl/swus_chain.sv @@
module swus_chain #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  swus_pkg::stk_ctl_t                 ctl,
  input  logic signed [swus_pkg::DATA_W-1:0] push_data,
  output logic signed [swus_pkg::DATA_W-1:0] top_data
);
  import swus_pkg::*;

  logic [DEPTH-1:0][DATA_W-1:0] cell_data;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] above;
    logic signed [DATA_W-1:0] below;

    if (i == 0) begin : g_first
      assign above = push_data;
    end else begin : g_inner_above
      assign above = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below = cell_data[i];
    end else begin : g_inner_below
      assign below = cell_data[i+1];
    end

    swus_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .above_data (above),
      .below_data (below),
      .data_o     (cell_data[i])
    );
  end

  assign top_data = cell_data[0];

endmodule

@@ rtl/stack_with_undo_stack_unit.sv @@
// Main stack and undo stack of signed 32-bit entries, STACK_DEPTH deep each, built as
// rows of cells that shift on push and pop so each top entry always sits in the first
// cell. An accepted item waits in a holding register and is executed in the next cycle
// in which the output register is free; the holding register frees only as its item
// moves on, so no new item is accepted while one is held, and output stalls keep it
// held longer. Every request returns one result item. There is no clearing pass after
// reset.
module stack_with_undo_stack_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swus_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output swus_pkg::out_item_t out_item
);
  import swus_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic        hold_valid_r;
  logic        hold_valid_nxt;
  in_item_t    hold_r;
  in_item_t    hold_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_r;
  out_item_t   out_nxt;
  logic [CNT_W-1:0] main_cnt_r;
  logic [CNT_W-1:0] main_cnt_nxt;
  logic [CNT_W-1:0] undo_cnt_r;
  logic [CNT_W-1:0] undo_cnt_nxt;

  logic               exec;
  logic               main_empty;
  logic               main_full;
  logic               undo_empty;
  logic               undo_full;
  stk_ctl_t           main_ctl;
  stk_ctl_t           undo_ctl;
  logic signed [DATA_W-1:0] main_top;
  logic signed [DATA_W-1:0] undo_top;
  logic signed [DATA_W-1:0] main_in;
  logic signed [DATA_W-1:0] res_value;
  logic [2:0]         res_status;

  assign in_ready   = !hold_valid_r;
  assign exec       = hold_valid_r && (!out_valid_r || out_ready);
  assign main_empty = (main_cnt_r == '0);
  assign main_full  = (main_cnt_r == FULL_CNT);
  assign undo_empty = (undo_cnt_r == '0);
  assign undo_full  = (undo_cnt_r == FULL_CNT);

  always_comb begin
    main_ctl     = '0;
    undo_ctl     = '0;
    main_in      = hold_r.push_value;
    res_value    = '0;
    res_status   = ST_OK;
    main_cnt_nxt = main_cnt_r;
    undo_cnt_nxt = undo_cnt_r;
    unique case (req_type_t'(hold_r.req_type))
      REQ_PUSH: begin
        if (main_full) begin
          res_status = ST_MAIN_FULL;
        end else begin
          main_ctl.push = exec;
        end
      end
      REQ_POP: begin
        if (main_empty) begin
          res_status = ST_MAIN_EMPTY;
        end else begin
          main_ctl.pop = exec;
          res_value    = main_top;
        end
      end
      REQ_MOVE: begin
        if (main_empty) begin
          res_status = ST_MAIN_EMPTY;
        end else if (undo_full) begin
          res_status = ST_UNDO_FULL;
        end else begin
          main_ctl.pop  = exec;
          undo_ctl.push = exec;
          res_value     = main_top;
        end
      end
      REQ_RESTORE: begin
        if (undo_empty) begin
          res_status = ST_UNDO_EMPTY;
        end else if (main_full) begin
          res_status = ST_MAIN_FULL;
        end else begin
          undo_ctl.pop  = exec;
          main_ctl.push = exec;
          main_in       = undo_top;
          res_value     = undo_top;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
    if (main_ctl.push) begin
      main_cnt_nxt = main_cnt_r + ONE_CNT;
    end else if (main_ctl.pop) begin
      main_cnt_nxt = main_cnt_r - ONE_CNT;
    end
    if (undo_ctl.push) begin
      undo_cnt_nxt = undo_cnt_r + ONE_CNT;
    end else if (undo_ctl.pop) begin
      undo_cnt_nxt = undo_cnt_r - ONE_CNT;
    end
  end

  always_comb begin
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    if (in_valid && in_ready) begin
      hold_nxt       = in_item;
      hold_valid_nxt = 1'b1;
    end else if (exec) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt      = 1'b1;
      out_nxt.out_value  = res_value;
      out_nxt.status     = res_status;
      out_nxt.main_depth = DEPTH_FIELD_W'(main_cnt_nxt);
      out_nxt.undo_depth = DEPTH_FIELD_W'(undo_cnt_nxt);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      main_cnt_r   <= '0;
      undo_cnt_r   <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      main_cnt_r   <= main_cnt_nxt;
      undo_cnt_r   <= undo_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  swus_chain #(
    .DEPTH (STACK_DEPTH)
  ) u_main (
    .clk       (clk),
    .ctl       (main_ctl),
    .push_data (main_in),
    .top_data  (main_top)
  );

  swus_chain #(
    .DEPTH (STACK_DEPTH)
  ) u_undo (
    .clk       (clk),
    .ctl       (undo_ctl),
    .push_data (main_top),
    .top_data  (undo_top)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

@@ rtl/swus_checker.sv @@
`include "stack_with_undo_stack_unit_defines.svh"

module swus_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input swus_pkg::out_item_t out_item
);
  import swus_pkg::*;

  logic in_acc;
  logic out_stall;
  logic is_err;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign is_err    = out_valid && (out_item.status != ST_OK);

  `SWUS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_item), "stalled item changed")
  `SWUS_ASSERT_NEXT(a_one_in_flight, in_acc, !in_ready, "second item accepted while one is held")
  `SWUS_ASSERT_NOW(a_status_code, out_valid, out_item.status <= ST_UNDO_FULL, "undefined status code")
  `SWUS_ASSERT_NOW(a_err_zero, is_err, out_item.out_value == '0, "error result carries a value")

endmodule

bind stack_with_undo_stack_unit swus_checker u_swus_checker (.*);
